// ===== rtl/core/arcpr_pkg.sv =====
// arcpr_pkg: shared constants, list codes and sequencer states for the ARC directory
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package arcpr_pkg;

  localparam int DIR_DEPTH = 256;
  localparam int IDX_W     = $clog2(DIR_DEPTH);
  localparam int CNT_W     = IDX_W + 1;
  localparam int CS_W      = 8;
  localparam int MAX_PAGES = 128;
  localparam int CS_RESET  = 100;
  localparam int KEY_W     = 64;
  localparam int HALF_W    = 32;
  localparam int LIST_W    = 3;

  typedef enum logic [LIST_W-1:0] {
    L_FREE = 3'd0,
    L_T1   = 3'd1,
    L_T2   = 3'd2,
    L_B1   = 3'd3,
    L_B2   = 3'd4
  } list_code_t;

  localparam logic [1:0] LI_T1 = 2'd0;
  localparam logic [1:0] LI_T2 = 2'd1;
  localparam logic [1:0] LI_B1 = 2'd2;
  localparam logic [1:0] LI_B2 = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ADAPT,
    ST_UL_RD,
    ST_UL_WR,
    ST_REPL,
    ST_REPL_PUSH,
    ST_PUSH_HIT,
    ST_MISS,
    ST_M_POPB1,
    ST_M_REPL2,
    ST_M_INS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/arcpr_ram.sv =====
// arcpr_ram: generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module arcpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/arcpr_div.sv =====
// arcpr_div: restoring divider, one quotient bit per cycle, for the ghost ratio
// depends on arcpr_pkg
`timescale 1ns / 1ps
`default_nettype none
module arcpr_div (
  input  wire                  clk,
  input  wire                  rst,
  input  arcpr_pkg::div_req_t  req,
  output arcpr_pkg::div_rsp_t  rsp
);
  import arcpr_pkg::*;

  localparam int STEP_W = $clog2(CNT_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  nq;
  logic [CNT_W-1:0]  dn;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  assign trial = {rem, nq[CNT_W-1]};
  assign diff  = trial - {1'b0, dn};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        nq   <= req.num;
        dn   <= req.den;
      end else if (busy) begin
        if (trial >= {1'b0, dn}) begin
          rem <= diff[CNT_W-1:0];
          nq  <= {nq[CNT_W-2:0], 1'b1};
        end else begin
          rem <= trial[CNT_W-1:0];
          nq  <= {nq[CNT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(CNT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = nq;

endmodule
`default_nettype wire

// ===== rtl/core/arc_page_replacement.sv =====
// arc_page_replacement: adaptive replacement cache directory, top level
// sequence: a linear scan of the key memory over the used entries, then the list updates
// throughput: one item at a time; the linear scan of the key memory sets the rate
// the output register lets the next item be taken while a result waits
// reset: synchronous, lists empty, cache_size 100, target 50; no memory clearing pass
// depends on arcpr_pkg, arcpr_ram, arcpr_div
`timescale 1ns / 1ps
`default_nettype none
module arc_page_replacement (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // file_id, block_number
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [79:0] m_tdata,   // hit, found_in, evicted_valid, evicted_file_id,
                                 // evicted_block, target_recent, zero fill
  input  wire         cfg_we,
  input  wire  [7:0]  cfg_wdata
);
  import arcpr_pkg::*;

  state_t            state, state_next;
  state_t            ul_ret, ul_ret_next;
  state_t            repl_ret, repl_ret_next;
  logic [KEY_W-1:0]  key, key_next;
  logic [CNT_W-1:0]  scan_idx, scan_idx_next;
  logic              pend, pend_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic [LIST_W-1:0] found, found_next;
  logic [IDX_W-1:0]  hit_idx, hit_idx_next;
  logic [IDX_W-1:0]  ul_idx, ul_idx_next;
  logic              ul_note, ul_note_next;
  logic              repl_t1, repl_t1_next;
  logic [IDX_W-1:0]  e_idx, e_idx_next;
  logic              e_ok, e_ok_next;
  logic              ev_valid, ev_valid_next;
  logic [KEY_W-1:0]  ev_key, ev_key_next;
  logic [IDX_W-1:0]  head [4];
  logic [IDX_W-1:0]  head_next [4];
  logic [IDX_W-1:0]  tail [4];
  logic [IDX_W-1:0]  tail_next [4];
  logic [CNT_W-1:0]  len [4];
  logic [CNT_W-1:0]  len_next [4];
  logic [CNT_W-1:0]  used, used_next;
  logic [CS_W-1:0]   target, target_next;
  logic [CS_W-1:0]   csize, csize_next;
  logic              m_tvalid_next;
  logic [79:0]       m_tdata_next;

  logic              key_we, list_we, nx_we, pv_we;
  logic [IDX_W-1:0]  key_wa, list_wa, nx_wa, pv_wa, rd_addr;
  logic [KEY_W-1:0]  key_wd, key_rd;
  logic [LIST_W-1:0] list_wd, list_rd;
  logic [IDX_W-1:0]  nx_wd, nx_rd, pv_wd, pv_rd;

  logic              push_en;
  logic [IDX_W-1:0]  push_i;
  logic [1:0]        push_l;
  logic              ul_wr;
  logic [1:0]        ul_l;
  logic [LIST_W-1:0] ul_code_m1;
  logic              tf_en;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [CNT_W-1:0]  div_d;
  logic [CS_W+1:0]   t_sum;
  logic [CS_W+1:0]   t1b1;
  logic [CS_W+2:0]   total;
  logic [CS_W-1:0]   thr;
  logic              from_t1;
  logic [CS_W-1:0]   cfg_c;

  arcpr_ram #(.WIDTH(KEY_W), .DEPTH(DIR_DEPTH)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(rd_addr), .rdata(key_rd)
  );
  arcpr_ram #(.WIDTH(LIST_W), .DEPTH(DIR_DEPTH)) u_list_ram (
    .clk(clk), .we(list_we), .waddr(list_wa), .wdata(list_wd), .raddr(rd_addr),
    .rdata(list_rd)
  );
  arcpr_ram #(.WIDTH(IDX_W), .DEPTH(DIR_DEPTH)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(rd_addr), .rdata(nx_rd)
  );
  arcpr_ram #(.WIDTH(IDX_W), .DEPTH(DIR_DEPTH)) u_prev_ram (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(rd_addr), .rdata(pv_rd)
  );

  arcpr_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp)
  );

  assign s_tready = (state == ST_IDLE) && !rst;
  assign rd_addr  = (state == ST_SCAN) ? scan_idx[IDX_W-1:0] : ul_idx;

  assign ul_code_m1 = list_rd - 3'd1;
  assign ul_l       = ul_code_m1[1:0];

  assign t1b1  = {1'b0, len[LI_T1]} + {1'b0, len[LI_B1]};
  assign total = {2'b0, len[LI_T1]} + {2'b0, len[LI_T2]} + {2'b0, len[LI_B1]}
               + {2'b0, len[LI_B2]};
  assign thr   = (target == '0) ? CS_W'(1) : target;

  always_comb begin
    from_t1 = (len[LI_T1] >= {1'b0, thr});
    if (!from_t1 && len[LI_T2] == '0) from_t1 = 1'b1;
    if (from_t1 && len[LI_T1] == '0) from_t1 = 1'b0;
  end

  assign div_d = (div_req.den == '0 || div_rsp.quo == '0) ? CNT_W'(1) : div_rsp.quo;
  assign t_sum = {2'b0, target} + {1'b0, div_d};

  always_comb begin
    if (cfg_wdata == '0) cfg_c = CS_W'(1);
    else if (cfg_wdata > CS_W'(MAX_PAGES)) cfg_c = CS_W'(MAX_PAGES);
    else cfg_c = cfg_wdata;
  end

  always_comb begin
    state_next    = state;
    ul_ret_next   = ul_ret;
    repl_ret_next = repl_ret;
    key_next      = key;
    scan_idx_next = scan_idx;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    found_next    = found;
    hit_idx_next  = hit_idx;
    ul_idx_next   = ul_idx;
    ul_note_next  = ul_note;
    repl_t1_next  = repl_t1;
    e_idx_next    = e_idx;
    e_ok_next     = e_ok;
    ev_valid_next = ev_valid;
    ev_key_next   = ev_key;
    head_next     = head;
    tail_next     = tail;
    len_next      = len;
    used_next     = used;
    target_next   = target;
    csize_next    = csize;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    key_we  = 1'b0; key_wa  = e_idx;  key_wd  = key;
    list_we = 1'b0; list_wa = push_i; list_wd = L_FREE;
    nx_we   = 1'b0; nx_wa   = '0;     nx_wd   = '0;
    pv_we   = 1'b0; pv_wa   = '0;     pv_wd   = '0;
    push_en = 1'b0; push_i  = hit_idx; push_l = LI_T2;
    ul_wr   = 1'b0;
    tf_en   = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = (found == L_B1) ? len[LI_B2] : len[LI_B1];
    div_req.den   = (found == L_B1) ? len[LI_B1] : len[LI_B2];

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          key_next      = {s_tdata[31:0], s_tdata[63:32]};
          scan_idx_next = '0;
          pend_next     = 1'b0;
          e_ok_next     = 1'b0;
          ev_valid_next = 1'b0;
          ev_key_next   = '0;
          found_next    = L_FREE;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend && list_rd != L_FREE && key_rd == key) begin
          found_next   = list_rd;
          hit_idx_next = pend_idx;
          ul_idx_next  = pend_idx;
          ul_note_next = 1'b0;
          pend_next    = 1'b0;
          if (list_rd == L_T1 || list_rd == L_T2) begin
            ul_ret_next = ST_PUSH_HIT;
            state_next  = ST_UL_RD;
          end else begin
            state_next  = ST_DIV_GO;
          end
        end else if (!pend && scan_idx >= used) begin
          state_next = ST_MISS;
        end else begin
          pend_next     = (scan_idx < used);
          pend_idx_next = scan_idx[IDX_W-1:0];
          if (scan_idx < used) scan_idx_next = scan_idx + 1'b1;
        end
      end
      ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) state_next = ST_ADAPT;
      end
      ST_ADAPT: begin
        if (found == L_B1) begin
          target_next = (t_sum > {2'b0, csize}) ? csize : t_sum[CS_W-1:0];
        end else begin
          target_next = ({1'b0, target} > div_d) ? target - div_d[CS_W-1:0] : '0;
        end
        ul_idx_next   = hit_idx;
        ul_note_next  = 1'b0;
        ul_ret_next   = ST_REPL;
        repl_ret_next = ST_PUSH_HIT;
        state_next    = ST_UL_RD;
      end
      ST_UL_RD: begin
        state_next = ST_UL_WR;
      end
      ST_UL_WR: begin
        ul_wr      = 1'b1;
        state_next = ul_ret;
      end
      ST_REPL: begin
        if ((from_t1 ? len[LI_T1] : len[LI_T2]) == '0) begin
          state_next = repl_ret;
        end else begin
          repl_t1_next = from_t1;
          ul_idx_next  = from_t1 ? tail[LI_T1] : tail[LI_T2];
          ul_note_next = 1'b1;
          ul_ret_next  = ST_REPL_PUSH;
          state_next   = ST_UL_RD;
        end
      end
      ST_REPL_PUSH: begin
        push_en    = 1'b1;
        push_i     = ul_idx;
        push_l     = repl_t1 ? LI_B1 : LI_B2;
        state_next = repl_ret;
      end
      ST_PUSH_HIT: begin
        push_en    = 1'b1;
        push_i     = hit_idx;
        push_l     = LI_T2;
        state_next = ST_DONE;
      end
      ST_MISS: begin
        if (t1b1 == {2'b0, csize}) begin
          if (len[LI_T1] < {1'b0, csize}) begin
            repl_ret_next = ST_M_POPB1;
            state_next    = ST_REPL;
          end else if (len[LI_T1] != '0) begin
            ul_idx_next  = tail[LI_T1];
            e_idx_next   = tail[LI_T1];
            e_ok_next    = 1'b1;
            ul_note_next = 1'b1;
            ul_ret_next  = ST_M_INS;
            state_next   = ST_UL_RD;
          end else begin
            tf_en      = 1'b1;
            state_next = ST_M_INS;
          end
        end else if (total >= {3'b0, csize}) begin
          if (total == {2'b0, csize, 1'b0} && len[LI_B2] != '0) begin
            ul_idx_next  = tail[LI_B2];
            e_idx_next   = tail[LI_B2];
            e_ok_next    = 1'b1;
            ul_note_next = 1'b0;
            ul_ret_next  = ST_M_REPL2;
            state_next   = ST_UL_RD;
          end else begin
            tf_en      = 1'b1;
            state_next = ST_M_REPL2;
          end
        end else begin
          tf_en      = 1'b1;
          state_next = ST_M_INS;
        end
      end
      ST_M_POPB1: begin
        if (len[LI_B1] != '0) begin
          ul_idx_next  = tail[LI_B1];
          e_idx_next   = tail[LI_B1];
          e_ok_next    = 1'b1;
          ul_note_next = 1'b0;
          ul_ret_next  = ST_M_INS;
          state_next   = ST_UL_RD;
        end else begin
          tf_en      = 1'b1;
          state_next = ST_M_INS;
        end
      end
      ST_M_REPL2: begin
        repl_ret_next = ST_M_INS;
        state_next    = ST_REPL;
      end
      ST_M_INS: begin
        if (e_ok) begin
          key_we  = 1'b1;
          push_en = 1'b1;
          push_i  = e_idx;
          push_l  = LI_T1;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {3'b0, target, ev_key[HALF_W-1:0], ev_key[KEY_W-1:HALF_W],
                           ev_valid, found,
                           (found == L_T1 || found == L_T2)};
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // take a fresh entry from the fill count
    if (tf_en) begin
      if (used != CNT_W'(DIR_DEPTH)) begin
        e_idx_next = used[IDX_W-1:0];
        e_ok_next  = 1'b1;
        used_next  = used + 1'b1;
      end else begin
        e_ok_next  = 1'b0;
      end
    end

    // unlink ul_idx with its links read back
    if (ul_wr) begin
      if (head[ul_l] == ul_idx) begin
        head_next[ul_l] = nx_rd;
      end else begin
        nx_we = 1'b1;
        nx_wa = pv_rd;
        nx_wd = nx_rd;
      end
      if (tail[ul_l] == ul_idx) begin
        tail_next[ul_l] = pv_rd;
      end else begin
        pv_we = 1'b1;
        pv_wa = nx_rd;
        pv_wd = pv_rd;
      end
      if (len[ul_l] != '0) len_next[ul_l] = len[ul_l] - 1'b1;
      if (ul_note) begin
        ev_valid_next = 1'b1;
        ev_key_next   = key_rd;
      end
    end

    // insert push_i at the mru end of push_l
    if (push_en) begin
      if (len[push_l] == '0) begin
        tail_next[push_l] = push_i;
      end else begin
        nx_we = 1'b1;
        nx_wa = push_i;
        nx_wd = head[push_l];
        pv_we = 1'b1;
        pv_wa = head[push_l];
        pv_wd = push_i;
      end
      head_next[push_l] = push_i;
      len_next[push_l]  = len[push_l] + 1'b1;
      list_we = 1'b1;
      list_wa = push_i;
      list_wd = {1'b0, push_l} + 3'd1;
    end

    if (cfg_we) begin
      csize_next  = cfg_c;
      target_next = cfg_c >> 1;
      used_next   = '0;
      for (int k = 0; k < 4; k++) begin
        head_next[k] = '0;
        tail_next[k] = '0;
        len_next[k]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ul_ret   <= ST_IDLE;
      repl_ret <= ST_IDLE;
      pend     <= 1'b0;
      e_ok     <= 1'b0;
      ev_valid <= 1'b0;
      used     <= '0;
      csize    <= CS_W'(CS_RESET);
      target   <= CS_W'(CS_RESET / 2);
      m_tvalid <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        head[k] <= '0;
        tail[k] <= '0;
        len[k]  <= '0;
      end
    end else begin
      state    <= state_next;
      ul_ret   <= ul_ret_next;
      repl_ret <= repl_ret_next;
      pend     <= pend_next;
      e_ok     <= e_ok_next;
      ev_valid <= ev_valid_next;
      used     <= used_next;
      csize    <= csize_next;
      target   <= target_next;
      m_tvalid <= m_tvalid_next;
      head     <= head_next;
      tail     <= tail_next;
      len      <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    key      <= key_next;
    scan_idx <= scan_idx_next;
    pend_idx <= pend_idx_next;
    found    <= found_next;
    hit_idx  <= hit_idx_next;
    ul_idx   <= ul_idx_next;
    ul_note  <= ul_note_next;
    repl_t1  <= repl_t1_next;
    e_idx    <= e_idx_next;
    ev_key   <= ev_key_next;
    m_tdata  <= m_tdata_next;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(DIR_DEPTH))
    else $error("fill count beyond directory depth");

  a_target_bound: assert property (@(posedge clk) disable iff (rst)
    target <= csize)
    else $error("t1 target above cache size");

  a_lists_match_fill: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |->
      ({2'b0, len[0]} + {2'b0, len[1]} + {2'b0, len[2]} + {2'b0, len[3]})
        == {2'b0, used})
    else $error("list lengths disagree with fill count");

  a_accept_scans: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_SCAN)
    else $error("accepted item did not start a lookup");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// testbench for arc_page_replacement: drives page accesses, predicts each result in a scoreboard
// depends on arcpr_pkg (list codes, sizes) and the arc_page_replacement rtl
`timescale 1ns / 1ps
import arcpr_pkg::*;

typedef struct {
  bit        hit;
  bit [2:0]  found_in;
  bit        evicted_valid;
  bit [31:0] evicted_file_id;
  bit [31:0] evicted_block;
  bit [7:0]  target_recent;
} access_result_t;

class arc_scoreboard;
  int unsigned size_now;
  bit [63:0] key_mem [DIR_DEPTH];
  bit [2:0]  list_of [DIR_DEPTH];
  bit [7:0]  nxt [DIR_DEPTH];
  bit [7:0]  prv [DIR_DEPTH];
  bit [7:0]  head [4];
  bit [7:0]  tail [4];
  int unsigned len [4];
  int unsigned target;
  bit        ev_flag;
  bit [63:0] ev_key;
  access_result_t pending [$];
  int errors, checked, hits, ghost_hits, evictions;

  function new();
    size_now = CS_RESET;
    clear_dir();
  endfunction

  function void clear_dir();
    foreach (key_mem[i]) begin
      key_mem[i] = '0; list_of[i] = L_FREE; nxt[i] = '0; prv[i] = '0;
    end
    for (int l = 0; l < 4; l++) begin
      head[l] = '0; tail[l] = '0; len[l] = 0;
    end
    target = size_now / 2;
  endfunction

  function void set_size(bit [7:0] v);
    int unsigned c;
    c = v;
    if (c < 1) c = 1;
    if (c > MAX_PAGES) c = MAX_PAGES;
    if (c > DIR_DEPTH / 2) c = DIR_DEPTH / 2;
    size_now = c;
    clear_dir();
  endfunction

  function void unlink(int unsigned i);
    int unsigned l;
    bit [7:0] p, n;
    l = (list_of[i] - 1) & 3;
    p = prv[i];
    n = nxt[i];
    if (head[l] == i) head[l] = n; else nxt[p] = n;
    if (tail[l] == i) tail[l] = p; else prv[n] = p;
    if (len[l] > 0) len[l]--;
    list_of[i] = L_FREE;
  endfunction

  function void push_front(int unsigned i, list_code_t code);
    int unsigned l;
    l = (code - 1) & 3;
    if (len[l] == 0) tail[l] = i;
    else begin
      nxt[i] = head[l];
      prv[head[l]] = i;
    end
    head[l] = i;
    len[l]++;
    list_of[i] = code;
  endfunction

  function int pop_back(list_code_t code);
    int unsigned l;
    int i;
    l = (code - 1) & 3;
    if (len[l] == 0) return -1;
    i = tail[l];
    unlink(i);
    return i;
  endfunction

  function int grab_free();
    for (int i = 0; i < DIR_DEPTH; i++)
      if (list_of[i] == L_FREE) return i;
    return -1;
  endfunction

  function void demote();
    int unsigned thr;
    bit from_t1;
    int i;
    thr = (target < 1) ? 1 : target;
    from_t1 = len[LI_T1] >= thr;
    if (!from_t1 && len[LI_T2] == 0) from_t1 = 1;
    if (from_t1 && len[LI_T1] == 0) from_t1 = 0;
    i = pop_back(from_t1 ? L_T1 : L_T2);
    if (i < 0) return;
    ev_flag = 1;
    ev_key = key_mem[i];
    push_front(i, from_t1 ? L_B1 : L_B2);
  endfunction

  function void note_access(bit [31:0] file_id, bit [31:0] block_number);
    bit [63:0] key;
    bit [2:0] found;
    int idx, e;
    int unsigned c, d, total;
    access_result_t r;
    key = {file_id, block_number};
    found = L_FREE;
    idx = -1;
    c = size_now;
    ev_flag = 0;
    ev_key = '0;
    for (int i = 0; i < DIR_DEPTH; i++)
      if (list_of[i] != L_FREE && key_mem[i] == key) begin
        idx = i; found = list_of[i]; break;
      end
    if (found == L_T1 || found == L_T2) begin
      hits++;
      unlink(idx);
      push_front(idx, L_T2);
    end else if (found == L_B1 || found == L_B2) begin
      ghost_hits++;
      if (found == L_B1) begin
        d = len[LI_B1] ? len[LI_B2] / len[LI_B1] : 1;
        if (d < 1) d = 1;
        target = (target + d > c) ? c : target + d;
      end else begin
        d = len[LI_B2] ? len[LI_B1] / len[LI_B2] : 1;
        if (d < 1) d = 1;
        target = (target > d) ? target - d : 0;
      end
      unlink(idx);
      demote();
      push_front(idx, L_T2);
    end else begin
      total = len[0] + len[1] + len[2] + len[3];
      e = -1;
      if (len[LI_T1] + len[LI_B1] == c) begin
        if (len[LI_T1] < c) begin
          demote();
          e = pop_back(L_B1);
        end else begin
          e = pop_back(L_T1);
          if (e >= 0) begin
            ev_flag = 1; ev_key = key_mem[e];
          end
        end
        if (e < 0) e = grab_free();
      end else if (total >= c) begin
        if (total == 2 * c) e = pop_back(L_B2);
        if (e < 0) e = grab_free();
        demote();
      end else e = grab_free();
      if (e >= 0) begin
        key_mem[e] = key;
        push_front(e, L_T1);
      end
    end
    if (ev_flag) evictions++;
    r.hit = (found == L_T1 || found == L_T2);
    r.found_in = found;
    r.evicted_valid = ev_flag;
    r.evicted_file_id = ev_flag ? ev_key[63:32] : '0;
    r.evicted_block = ev_flag ? ev_key[31:0] : '0;
    r.target_recent = target[7:0];
    pending.push_back(r);
  endfunction

  function void check_result(logic [79:0] d);
    access_result_t x;
    if (pending.size() == 0) begin
      $error("result with no access outstanding: %h", d);
      errors++;
      return;
    end
    x = pending.pop_front();
    checked++;
    if (d[0] !== x.hit) begin
      $error("hit: expected %0d, got %0d", x.hit, d[0]); errors++;
    end
    if (d[3:1] !== x.found_in) begin
      $error("found_in: expected %0d, got %0d", x.found_in, d[3:1]); errors++;
    end
    if (d[4] !== x.evicted_valid) begin
      $error("evicted_valid: expected %0d, got %0d", x.evicted_valid, d[4]); errors++;
    end
    if (d[36:5] !== x.evicted_file_id) begin
      $error("evicted_file_id: expected %h, got %h", x.evicted_file_id, d[36:5]); errors++;
    end
    if (d[68:37] !== x.evicted_block) begin
      $error("evicted_block: expected %h, got %h", x.evicted_block, d[68:37]); errors++;
    end
    if (d[76:69] !== x.target_recent) begin
      $error("target_recent: expected %0d, got %0d", x.target_recent, d[76:69]); errors++;
    end
  endfunction
endclass

module testbench;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [79:0] m_tdata;
  logic        cfg_we = 0;
  logic [7:0]  cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit [63:0] key_pool [512];
  int pool_n;
  arc_scoreboard sb = new();

  arc_page_replacement DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_access(s_tdata[31:0], s_tdata[63:32]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  task automatic send_access(bit [31:0] file_id, bit [31:0] block_number);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {block_number, file_id};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_size(bit [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_size(v);
  endtask

  task automatic run_random(int n);
    bit [63:0] k;
    pool_n = 2 * sb.size_now + sb.size_now / 2 + 2;
    for (int i = 0; i < pool_n; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) k = {$urandom, $urandom};
      else k = key_pool[$urandom_range(pool_n - 1)];
      send_access(k[63:32], k[31:0]);
    end
  endtask

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    bit [7:0] sizes [10];
    sizes = '{8'd100, 8'd0, 8'd1, 8'd2, 8'd5, 8'd16, 8'd255, 8'd128, 8'd64, 8'd37};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // extremes and repeat hits at the reset size
    send_access(32'h0, 32'h0);
    send_access(32'hffffffff, 32'hffffffff);
    send_access(32'h0, 32'h0);
    send_access(32'h0, 32'h0);
    send_access(32'hffffffff, 32'h0);
    send_access(32'h0, 32'hffffffff);
    send_access(32'h55555555, 32'haaaaaaaa);
    send_access(32'haaaaaaaa, 32'h55555555);
    // tiny cache: full recent list, ghost hits both ways
    write_size(8'd2);
    send_access(32'd1, 32'd1);
    send_access(32'd1, 32'd1);
    send_access(32'd2, 32'd2);
    send_access(32'd3, 32'd3);
    send_access(32'd2, 32'd2);
    send_access(32'd4, 32'd4);
    send_access(32'd1, 32'd1);
    send_access(32'd5, 32'd5);
    send_access(32'd6, 32'd6);
    send_access(32'd7, 32'd7);
    send_access(32'd3, 32'd3);
    send_access(32'd1, 32'd1);
    send_access(32'd8, 32'd8);
    send_access(32'd9, 32'd9);
    write_size(8'd1);
    send_access(32'd1, 32'd1);
    send_access(32'd2, 32'd2);
    send_access(32'd1, 32'd1);
    for (int p = 0; p < 10; p++) begin
      write_size(sizes[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      run_random(180);
    end
    drain();
    $display("checked %0d results: %0d resident hits, %0d ghost hits, %0d evictions",
             sb.checked, sb.hits, sb.ghost_hits, sb.evictions);
    $display("cache sizes 1, 2, 5, 16, 37, 64, 100, 128 including clamped writes of 0 and 255");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
